// File: hdl/rmn_pkg.sv
package rmn_pkg;

	// Number of color channels handled side by side
	localparam int LANES = 3;

	// Default sample format
	localparam int SAMPLE_WIDTH_DEF  = 24;
	localparam int FRACTION_BITS_DEF = 16;

	// Configuration register map
	localparam int CFG_INDEX_WIDTH = 3;
	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_RED_LOW    = 3'd0,
		REG_RED_HIGH   = 3'd1,
		REG_GREEN_LOW  = 3'd2,
		REG_GREEN_HIGH = 3'd3,
		REG_BLUE_LOW   = 3'd4,
		REG_BLUE_HIGH  = 3'd5
	} reg_index_t;
	localparam int NUM_REGS = 6;

	// Result class of one channel, settled before the divider chain
	typedef enum logic [1:0] {
		CLS_ZERO = 2'd0,
		CLS_FULL = 2'd1,
		CLS_DIV  = 2'd2
	} cls_t;

	// Quotient bits: one divider cell per output bit
	localparam int BYTE_BITS = 8;
	localparam logic [BYTE_BITS-1:0] BYTE_MAX = 8'd255;

endpackage

// File: hdl/rgb_minmax_normalize_to_bytes.sv
// Min-max normalization of RGB pixels to bytes. Each channel gives
// floor(255 * (value - low) / (high - low)), clamped to 0..255, and 0 when the
// channel's valid flag is low; a zero range counts as 1.0. One pixel is taken
// per clock while the output is not stalled, through two front-end stages, a
// chain of eight divider cells (one quotient bit each, all three channels in
// parallel) and the output register, all holding while a result waits unaccepted.
// Bounds go in via cfg (index 0..5: red low/high, green low/high, blue low/high);
// the user must write them only while idle, which the block does not enforce.
module rgb_minmax_normalize_to_bytes #(
	parameter int SAMPLE_WIDTH  = rmn_pkg::SAMPLE_WIDTH_DEF,
	parameter int FRACTION_BITS = rmn_pkg::FRACTION_BITS_DEF
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             s_tvalid,
	output logic                                             s_tready,
	// red_value, red_valid, green_value, green_valid, blue_value, blue_valid
	input  logic [((3*(SAMPLE_WIDTH+1)+7)/8)*8-1:0]          s_tdata,
	output logic                                             m_tvalid,
	input  logic                                             m_tready,
	// red_byte, green_byte, blue_byte
	output logic [3*rmn_pkg::BYTE_BITS-1:0]                  m_tdata,
	input  logic                                             cfg_valid,
	output logic                                             cfg_ready,
	input  logic [rmn_pkg::CFG_INDEX_WIDTH-1:0]              cfg_index,
	input  logic [SAMPLE_WIDTH-1:0]                          cfg_data
);
	localparam int QW = SAMPLE_WIDTH + rmn_pkg::BYTE_BITS;
	localparam int NB = rmn_pkg::BYTE_BITS;
	localparam int NL = rmn_pkg::LANES;
	localparam int CW = SAMPLE_WIDTH + 1;

	logic                    en;
	logic [SAMPLE_WIDTH-1:0] regs_q [rmn_pkg::NUM_REGS];
	logic [1:0]              vld_s;
	logic [QW-1:0]           rem_c [NB+1][NL];
	logic [SAMPLE_WIDTH-1:0] div_c [NB+1][NL];
	logic [NB-1:0]           quo_c [NB+1][NL];
	rmn_pkg::cls_t           cls_c [NB+1][NL];
	logic [NB:0]             vld_c;
	logic [NB-1:0]           byte_c [NL];

	// Whole pipeline moves unless a result is held at the output
	assign en        = !m_tvalid || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	// Bound registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < rmn_pkg::NUM_REGS; r += 2) begin
				regs_q[r]   <= '0;
				regs_q[r+1] <= SAMPLE_WIDTH'(1) << FRACTION_BITS;
			end
		end else if (cfg_valid && cfg_index < rmn_pkg::CFG_INDEX_WIDTH'(rmn_pkg::NUM_REGS)) begin
			regs_q[cfg_index] <= cfg_data;
		end
	end

	// Front end per channel
	for (genvar l = 0; l < NL; l++) begin : g_prep
		rmn_prep #(
			.SAMPLE_WIDTH (SAMPLE_WIDTH),
			.FRACTION_BITS(FRACTION_BITS)
		) u_prep (
			.clk     (clk),
			.en      (en),
			.value   (s_tdata[l*CW +: SAMPLE_WIDTH]),
			.ok      (s_tdata[l*CW + SAMPLE_WIDTH]),
			.low     (regs_q[2*l]),
			.high    (regs_q[2*l+1]),
			.dividend(rem_c[0][l]),
			.divisor (div_c[0][l]),
			.cls     (cls_c[0][l])
		);
		assign quo_c[0][l] = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[0], s_tvalid};
		end
	end
	assign vld_c[0] = vld_s[1];

	// Divider chain, most significant quotient bit first
	for (genvar k = 0; k < NB; k++) begin : g_cell
		rmn_div_cell #(
			.SAMPLE_WIDTH(SAMPLE_WIDTH),
			.SHIFT       (NB-1-k)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.vld_i (vld_c[k]),
			.rem_i (rem_c[k]),
			.div_i (div_c[k]),
			.quo_i (quo_c[k]),
			.cls_i (cls_c[k]),
			.vld_q (vld_c[k+1]),
			.rem_q (rem_c[k+1]),
			.div_q (div_c[k+1]),
			.quo_q (quo_c[k+1]),
			.cls_q (cls_c[k+1])
		);
	end

	// Final byte select and output register
	always_comb begin
		for (int l = 0; l < NL; l++) begin
			case (cls_c[NB][l])
				rmn_pkg::CLS_FULL: byte_c[l] = rmn_pkg::BYTE_MAX;
				rmn_pkg::CLS_DIV:  byte_c[l] = quo_c[NB][l];
				default:           byte_c[l] = '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < NL; l++) begin
				m_tdata[l*NB +: NB] <= byte_c[l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= vld_c[NB];
		end
	end

	// A result leaving the chain reaches the output register
	a_chain_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_c[NB] |=> m_tvalid)
		else $error("chain result lost at output");

	// A held result keeps the whole chain still
	a_hold_chain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(vld_c) && $stable(vld_s))
		else $error("pipeline moved during output stall");

	// A clamped-high red class always yields 255
	a_full_byte: assert property (@(posedge clk) disable iff (!arst_n)
		en && cls_c[NB][0] == rmn_pkg::CLS_FULL |=> m_tdata[NB-1:0] == rmn_pkg::BYTE_MAX)
		else $error("full-scale red not 255");

endmodule

// File: hdl/rmn_prep.sv
// Two-stage front end for one channel: offset and range, then classify
// and form the dividend 255 * num.
module rmn_prep #(
	parameter int SAMPLE_WIDTH  = rmn_pkg::SAMPLE_WIDTH_DEF,
	parameter int FRACTION_BITS = rmn_pkg::FRACTION_BITS_DEF
) (
	input  logic                                       clk,
	input  logic                                       en,
	input  logic signed [SAMPLE_WIDTH-1:0]             value,
	input  logic                                       ok,
	input  logic signed [SAMPLE_WIDTH-1:0]             low,
	input  logic signed [SAMPLE_WIDTH-1:0]             high,
	output logic [SAMPLE_WIDTH+rmn_pkg::BYTE_BITS-1:0] dividend,
	output logic [SAMPLE_WIDTH-1:0]                    divisor,
	output rmn_pkg::cls_t                              cls
);
	localparam int DW = SAMPLE_WIDTH + 1;
	localparam int QW = SAMPLE_WIDTH + rmn_pkg::BYTE_BITS;

	logic signed [DW-1:0] num_c, rng_c, num_fix, rng_fix;
	logic signed [DW-1:0] num_s1, rng_s1;
	logic                 ok_s1;
	logic [QW-1:0]        num_w;

	// Stage 1: signed differences, zero range replaced by 1.0, negative range negated along with the offset
	always_comb begin
		num_c = DW'(value) - DW'(low);
		rng_c = DW'(high) - DW'(low);
		if (rng_c == '0) begin
			rng_c = DW'(1) <<< FRACTION_BITS;
		end
		num_fix = num_c;
		rng_fix = rng_c;
		if (rng_c < 0) begin
			num_fix = -num_c;
			rng_fix = -rng_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1 <= num_fix;
			rng_s1 <= rng_fix;
			ok_s1  <= ok;
		end
	end

	// Stage 2: clamp class and dividend 256*num - num
	assign num_w = QW'(num_s1[SAMPLE_WIDTH-1:0]);

	always_ff @(posedge clk) begin
		if (en) begin
			if (!ok_s1 || num_s1 <= 0) begin
				cls <= rmn_pkg::CLS_ZERO;
			end else if (num_s1 >= rng_s1) begin
				cls <= rmn_pkg::CLS_FULL;
			end else begin
				cls <= rmn_pkg::CLS_DIV;
			end
			dividend <= (num_w << rmn_pkg::BYTE_BITS) - num_w;
			divisor  <= rng_s1[SAMPLE_WIDTH-1:0];
		end
	end

endmodule

// File: hdl/rmn_div_cell.sv
// One restoring-division cell: settles quotient bit SHIFT for all lanes.
module rmn_div_cell #(
	parameter int SAMPLE_WIDTH = rmn_pkg::SAMPLE_WIDTH_DEF,
	parameter int SHIFT        = 0
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       en,
	input  logic                                       vld_i,
	input  logic [SAMPLE_WIDTH+rmn_pkg::BYTE_BITS-1:0] rem_i [rmn_pkg::LANES],
	input  logic [SAMPLE_WIDTH-1:0]                    div_i [rmn_pkg::LANES],
	input  logic [rmn_pkg::BYTE_BITS-1:0]              quo_i [rmn_pkg::LANES],
	input  rmn_pkg::cls_t                              cls_i [rmn_pkg::LANES],
	output logic                                       vld_q,
	output logic [SAMPLE_WIDTH+rmn_pkg::BYTE_BITS-1:0] rem_q [rmn_pkg::LANES],
	output logic [SAMPLE_WIDTH-1:0]                    div_q [rmn_pkg::LANES],
	output logic [rmn_pkg::BYTE_BITS-1:0]              quo_q [rmn_pkg::LANES],
	output rmn_pkg::cls_t                              cls_q [rmn_pkg::LANES]
);
	localparam int QW = SAMPLE_WIDTH + rmn_pkg::BYTE_BITS;

	logic [QW:0] trial [rmn_pkg::LANES];

	// Trial subtract of the shifted divisor per lane
	always_comb begin
		for (int l = 0; l < rmn_pkg::LANES; l++) begin
			trial[l] = {1'b0, rem_i[l]} - ((QW+1)'(div_i[l]) << SHIFT);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < rmn_pkg::LANES; l++) begin
				div_q[l] <= div_i[l];
				cls_q[l] <= cls_i[l];
				if (!trial[l][QW]) begin
					rem_q[l] <= trial[l][QW-1:0];
					quo_q[l] <= quo_i[l] | (rmn_pkg::BYTE_BITS'(1) << SHIFT);
				end else begin
					rem_q[l] <= rem_i[l];
					quo_q[l] <= quo_i[l];
				end
			end
		end
	end

	// Valid marker travels with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

endmodule

// File: sim/tb_rgb_minmax_normalize_to_bytes.sv
module tb_rgb_minmax_normalize_to_bytes;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SW = rmn_pkg::SAMPLE_WIDTH_DEF;
	localparam int FB = rmn_pkg::FRACTION_BITS_DEF;
	localparam int BB = rmn_pkg::BYTE_BITS;
	localparam int IN_W = ((3*(SW+1)+7)/8)*8;
	localparam int PIPE_CYCLES = 11;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_PIXELS = 1750;

	typedef struct {
		logic signed [SW-1:0] value;
		logic                 ok;
	} sample_t;

	// pixel normalizer with its own copy of the bounds
	class pixel_scoreboard;
		logic signed [SW-1:0] bound_lo [3];
		logic signed [SW-1:0] bound_hi [3];
		logic [3*BB-1:0] pending_bytes [$];
		int mismatches;

		function new();
			for (int c = 0; c < 3; c++) begin
				bound_lo[c] = '0;
				bound_hi[c] = SW'(1 << FB);
			end
			mismatches = 0;
		endfunction

		function void set_bound(rmn_pkg::reg_index_t idx, logic [SW-1:0] val);
			if (idx[0])
				bound_hi[idx >> 1] = val;
			else
				bound_lo[idx >> 1] = val;
		endfunction

		function logic [7:0] channel_byte(sample_t s, int c);
			longint num;
			longint span;
			if (!s.ok)
				return 8'd0;
			num = longint'(s.value) - longint'(bound_lo[c]);
			span = longint'(bound_hi[c]) - longint'(bound_lo[c]);
			if (span == 0)
				span = longint'(1) << FB;
			if (span < 0) begin
				span = -span;
				num = -num;
			end
			if (num <= 0)
				return 8'd0;
			if (num >= span)
				return rmn_pkg::BYTE_MAX;
			return 8'((num * 255) / span);
		endfunction

		function void note_pixel(logic [IN_W-1:0] word);
			sample_t s;
			logic [3*BB-1:0] bytes;
			for (int c = 0; c < 3; c++) begin
				s.value = word[c*(SW+1) +: SW];
				s.ok = word[c*(SW+1) + SW];
				bytes[c*8 +: 8] = channel_byte(s, c);
			end
			pending_bytes.push_back(bytes);
		endfunction

		function void check_bytes(logic [3*BB-1:0] got);
			logic [3*BB-1:0] want;
			if (pending_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", got);
				return;
			end
			want = pending_bytes.pop_front();
			for (int c = 0; c < 3; c++)
				if (got[c*8 +: 8] !== want[c*8 +: 8]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("channel %0d: expected %0d got %0d", c,
							want[c*8 +: 8], got[c*8 +: 8]);
				end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [3*BB-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [rmn_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [SW-1:0] cfg_data = '0;

	pixel_scoreboard sb = new();
	bit stim_done = 0;
	bit hold_off = 0;
	int idle_cycles = 0;

	rgb_minmax_normalize_to_bytes i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int gap_len();
		return ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
	endfunction

	// sample transactions at the rising edge
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			sb.note_pixel(s_tdata);
		if (m_tvalid && m_tready)
			sb.check_bytes(m_tdata);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	// watchdog
	always @(posedge clk)
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end

	// receiver: random stalls, long hold-off on request
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				m_tready <= 1'b0;
				for (n = 0; n < 200; n++)
					@(negedge clk);
				hold_off = 0;
			end
			n = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
			if (stim_done && $urandom_range(0, 1))
				n = 0;
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	task automatic write_bound(rmn_pkg::reg_index_t idx, logic [SW-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_bound(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_pixel(logic [IN_W-1:0] word, bit allow_gap);
		int g;
		g = allow_gap && $urandom_range(0, 2) == 0 ? gap_len() : 0;
		@(negedge clk);
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic end_burst();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic drain();
		end_burst();
		while (sb.pending_bytes.size() != 0)
			@(posedge clk);
		repeat (PIPE_CYCLES + 2) @(posedge clk);
	endtask

	function automatic logic [IN_W-1:0] make_pixel(logic [SW-1:0] r, bit rv,
		logic [SW-1:0] g, bit gv, logic [SW-1:0] b, bit bv);
		logic [IN_W-1:0] w;
		w = '0;
		w[0 +: SW+1] = {rv, r};
		w[SW+1 +: SW+1] = {gv, g};
		w[2*(SW+1) +: SW+1] = {bv, b};
		return w;
	endfunction

	function automatic logic [SW-1:0] near_bound(int c);
		logic signed [SW-1:0] lo, hi;
		lo = sb.bound_lo[c];
		hi = sb.bound_hi[c];
		case ($urandom_range(0, 5))
			0: return SW'($urandom());
			1: return lo + SW'($signed($urandom_range(0, 8)) - 4);
			2: return hi + SW'($signed($urandom_range(0, 8)) - 4);
			default: return SW'((longint'(lo) + longint'(hi)) / 2
				+ (longint'($urandom()) % (longint'(hi) - longint'(lo) + 1)));
		endcase
	endfunction

	task automatic random_bounds(int mode);
		logic [SW-1:0] lo, hi;
		for (int c = 0; c < 3; c++) begin
			case (mode)
				0: begin lo = {1'b1, {(SW-1){1'b0}}}; hi = {1'b0, {(SW-1){1'b1}}}; end
				1: begin lo = {1'b0, {(SW-1){1'b1}}}; hi = {1'b1, {(SW-1){1'b0}}}; end
				2: begin lo = SW'($urandom()); hi = lo; end
				3: begin lo = SW'($urandom()); hi = lo + SW'($urandom_range(1, 300)); end
				default: begin lo = SW'($urandom()); hi = SW'($urandom()); end
			endcase
			write_bound(rmn_pkg::reg_index_t'(2*c), lo);
			write_bound(rmn_pkg::reg_index_t'(2*c + 1), hi);
		end
	endtask

	initial begin
		logic [SW-1:0] mx, mn;
		mx = {1'b0, {(SW-1){1'b1}}};
		mn = {1'b1, {(SW-1){1'b0}}};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// directed: reset bounds, extremes, invalid flags, in-range fractions
		send_pixel(make_pixel(mx, 1, mn, 1, 24'h0, 1), 0);
		send_pixel(make_pixel(mx, 0, mn, 0, 24'h8000, 0), 0);
		send_pixel(make_pixel(24'h8000, 1, 24'h10000, 1, 24'h0FFFF, 1), 0);
		send_pixel(make_pixel(24'h1, 1, 24'hFFFFFF, 1, 24'h10001, 1), 0);
		send_pixel(make_pixel(24'hFFFFFF, 0, 24'h0, 1, mx, 0), 0);
		drain();
		// full-scale, inverted, zero range
		for (int m = 0; m < 3; m++) begin
			random_bounds(m);
			send_pixel(make_pixel(mx, 1, mn, 1, 24'h0, 1), 0);
			send_pixel(make_pixel(mn, 1, 24'h0, 1, mx, 1), 0);
			send_pixel(make_pixel(24'h1, 1, 24'hFFFFFF, 1, 24'h8000, 1), 0);
			send_pixel(make_pixel(24'h0, 0, mx, 0, mn, 0), 0);
			for (int k = 0; k < 3; k++)
				send_pixel(make_pixel(near_bound(0), 1, near_bound(1), 1, near_bound(2), 1), 0);
			drain();
		end

		// random phases with fresh bounds
		for (int p = 0; p < 14; p++) begin
			random_bounds(p % 5);
			if (p == 3)
				hold_off = 1;
			for (int k = 0; k < RANDOM_PIXELS / 14; k++)
				send_pixel(make_pixel(near_bound(0), $urandom_range(0, 7) != 0,
					near_bound(1), $urandom_range(0, 7) != 0,
					near_bound(2), $urandom_range(0, 7) != 0), p != 3);
			drain();
		end

		stim_done = 1;
		repeat (PIPE_CYCLES * 4) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_bytes.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
